>>> rtl/page_state_tree_update_assert.svh
// Assertion macros shared by the page state tree checker.
`ifndef PAGE_STATE_TREE_UPDATE_ASSERT_SVH
`define PAGE_STATE_TREE_UPDATE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define PST_ASSERT_IMPL(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define PST_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> rtl/pst_pkg.sv
// Types and constants for the page state tree update block.
package pst_pkg;

    // Width of the page index field on the command port.
    localparam int PAGE_FIELD_W = 10;

    // Two-bit state of one tree node.
    typedef enum logic [1:0] {
        ST_AVAIL   = 2'd0,
        ST_UNAVAIL = 2'd1,
        ST_PARTIAL = 2'd2,
        ST_FULL    = 2'd3
    } node_state_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_UNAVAIL = 2'd1,
        STATUS_FULL    = 2'd2
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK
    } fsm_state_t;

endpackage

>>> rtl/page_state_tree_update.sv
// Top level of the page state tree update block.
//
// A command beat (start high while busy is low) marks one page unavailable
// or full and walks up the tree of node states. The result beat is on
// done/status/root_state from registers set as the walk ends: the walk retires
// one tree level per cycle, reading parent and sibling together from the
// two read ports of the node-state memory, and ends early when an ancestor
// stops it. busy falls in the cycle the result is shown, so a new command
// can be given while the result beat is out.
// The result cannot be held off; it is valid for exactly one cycle. After
// reset the memory is cleared one entry per cycle, all 2^(PAGE_INDEX_BITS+1)-1
// entries (2047 at the default size), and busy stays high until that is done.
module page_state_tree_update
    import pst_pkg::*;
#(
    parameter int PAGE_INDEX_BITS = 10
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    kind,
    input  logic [PAGE_FIELD_W-1:0] page_index,
    output logic                    done,
    output logic [1:0]              status,
    output logic [1:0]              root_state
);

    localparam int ADDR_W = PAGE_INDEX_BITS + 1;
    localparam int DEPTH  = (1 << ADDR_W) - 1;
    localparam logic [ADDR_W-1:0] LEAF_BASE = ADDR_W'((1 << PAGE_INDEX_BITS) - 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [ADDR_W-1:0] ROOT_ADDR = '0;

    fsm_state_t           state_reg, state_next;
    logic [ADDR_W-1:0]    clr_reg, clr_next;
    logic                 done_reg, done_next;
    node_state_t          root_reg, root_next;
    logic [ADDR_W-1:0]    cur_reg, cur_next;
    node_state_t          cur_st_reg, cur_st_next;
    status_t              status_reg, status_next;
    node_state_t          root_out_reg, root_out_next;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    node_state_t          ram_wdata;
    logic [ADDR_W-1:0]    ram_raddr_a, ram_raddr_b;
    logic [1:0]           ram_rdata_a, ram_rdata_b;

    logic [PAGE_INDEX_BITS-1:0] page_w;
    logic [ADDR_W-1:0]    leaf_addr;
    logic [ADDR_W-1:0]    par_addr;
    logic [ADDR_W-1:0]    src_addr;

    // Leaf position in heap order; high index bits beyond the tree are dropped.
    assign page_w    = PAGE_INDEX_BITS'(page_index);
    assign leaf_addr = LEAF_BASE + ADDR_W'(page_w);

    // Parent of the node the walk came from.
    assign par_addr = (cur_reg - ADDR_W'(1)) >> 1;

    // Next reads are the parent and sibling of the leaf or of this level's node.
    assign src_addr = (state_reg == S_IDLE) ? leaf_addr : par_addr;

    always_comb
    begin
        if (src_addr == ROOT_ADDR)
        begin
            ram_raddr_a = ROOT_ADDR;
            ram_raddr_b = ROOT_ADDR;
        end
        else
        begin
            ram_raddr_a = (src_addr - ADDR_W'(1)) >> 1;
            ram_raddr_b = src_addr[0] ? (src_addr + ADDR_W'(1)) : (src_addr - ADDR_W'(1));
        end
    end

    // Node-state memory.
    pst_ram #(
        .WIDTH (2),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .rdata_a (ram_rdata_a),
        .raddr_b (ram_raddr_b),
        .rdata_b (ram_rdata_b)
    );

    // Next state, memory writes and result capture.
    always_comb
    begin
        node_state_t par_st;
        node_state_t sib_st;
        logic        go_up;
        logic        finish;
        status_t     fin_status;

        par_st        = node_state_t'(ram_rdata_a);
        sib_st        = node_state_t'(ram_rdata_b);
        go_up         = 1'b0;
        finish        = 1'b0;
        fin_status    = STATUS_OK;

        state_next    = state_reg;
        clr_next      = clr_reg;
        done_next     = 1'b0;
        root_next     = root_reg;
        cur_next      = cur_reg;
        cur_st_next   = cur_st_reg;
        status_next   = status_reg;
        root_out_next = root_out_reg;
        ram_we        = 1'b0;
        ram_waddr     = par_addr;
        ram_wdata     = ST_AVAIL;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = ST_AVAIL;
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + ADDR_W'(1);
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    ram_we      = 1'b1;
                    ram_waddr   = leaf_addr;
                    ram_wdata   = kind ? ST_FULL : ST_UNAVAIL;
                    cur_next    = leaf_addr;
                    cur_st_next = ram_wdata;
                    state_next  = S_WALK;
                end
            end

            S_WALK:
            begin
                // Update the parent from its own state and both children.
                case (par_st)
                    ST_AVAIL:
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = ST_PARTIAL;
                        go_up     = 1'b1;
                    end
                    ST_UNAVAIL:
                    begin
                        finish     = 1'b1;
                        fin_status = STATUS_UNAVAIL;
                    end
                    ST_FULL:
                    begin
                        finish     = 1'b1;
                        fin_status = STATUS_FULL;
                    end
                    ST_PARTIAL:
                    begin
                        if (cur_st_reg == ST_AVAIL || cur_st_reg == ST_PARTIAL ||
                            sib_st == ST_AVAIL || sib_st == ST_PARTIAL)
                        begin
                            finish = 1'b1;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = (cur_st_reg == ST_UNAVAIL && sib_st == ST_UNAVAIL)
                                        ? ST_UNAVAIL : ST_FULL;
                            go_up     = 1'b1;
                        end
                    end
                    default:
                    begin
                        finish = 1'b1;
                    end
                endcase

                // The root has no parent: the walk ends after it.
                if (go_up)
                begin
                    if (par_addr == ROOT_ADDR)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        cur_next    = par_addr;
                        cur_st_next = ram_wdata;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Keep a copy of the root so the result needs no extra read.
        if (ram_we && ram_waddr == ROOT_ADDR)
        begin
            root_next = ram_wdata;
        end

        if (finish)
        begin
            done_next     = 1'b1;
            status_next   = fin_status;
            root_out_next = root_next;
            state_next    = S_IDLE;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
            root_reg  <= ST_AVAIL;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
            root_reg  <= root_next;
        end
    end

    // Walk position and result payload.
    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        cur_st_reg   <= cur_st_next;
        status_reg   <= status_next;
        root_out_reg <= root_out_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign root_state = root_out_reg;

endmodule

>>> rtl/pst_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
module pst_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 2047
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read ports.
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

>>> rtl/pst_checker.sv
// Port-level checker for the page state tree update block, with its bind.
`include "page_state_tree_update_assert.svh"

module pst_checker
    import pst_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [1:0] status
);

    // An accepted command always starts a walk.
    `PST_ASSERT_IMPL(a_accept_busy, (start && !busy) |=> busy, "accept did not raise busy")

    // No result beat appears in the cycle after an accepted command.
    `PST_ASSERT_IMPL(a_no_early_done, (start && !busy) |=> !done, "result in cycle after accept")

    // Each result beat closes a walk that was in progress.
    `PST_ASSERT_IMPL(a_done_after_busy, done |-> $past(busy), "result without a walk")

    // Results are single beats.
    `PST_ASSERT_IMPL(a_done_single, done |=> !done, "two result beats in a row")

    // The unused status code never appears on a result.
    `PST_ASSERT_NEVER(a_status_code, done && status == 2'd3, "reserved status code")

endmodule

bind page_state_tree_update pst_checker u_pst_checker (.*);

>>> test/page_state_tree_update_test.sv
// Self-checking testbench for the page state tree update block.
module page_state_tree_update_test;
    import pst_pkg::*;

    localparam int PAGE_BITS    = 10;
    localparam int LEAF_COUNT   = 1 << PAGE_BITS;
    localparam int TREE_NODES   = (1 << (PAGE_BITS + 1)) - 1;
    localparam int RANDOM_ITEMS = 1000;
    localparam int SETTLE       = 2 * PAGE_BITS + 8;
    // The clearing pass over all 2047 tree nodes after reset counts as quiet.
    localparam int QUIET_LIMIT  = 8000;

    // Block kinds for random runs of neighboring pages.
    typedef enum int {
        RUN_UNAVAIL,
        RUN_FULL,
        RUN_MIXED
    } run_mode_t;

    // One expected result beat, tagged with the page that caused it.
    typedef struct {
        logic [PAGE_FIELD_W-1:0] page;
        status_t                 status;
        node_state_t             root;
    } mark_outcome_t;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic                    kind;
    logic [PAGE_FIELD_W-1:0] page_index;
    logic                    done;
    logic [1:0]              status;
    logic [1:0]              root_state;

    node_state_t   tree_model [0:TREE_NODES-1];
    mark_outcome_t owed_outcomes [$];
    int            mismatch_count;
    int            items_sent;
    int            quiet_cycles;
    bit            no_gaps;

    page_state_tree_update #(
        .PAGE_INDEX_BITS(PAGE_BITS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .kind       (kind),
        .page_index (page_index),
        .done       (done),
        .status     (status),
        .root_state (root_state)
    );

    // Free-running clock, period 8.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Flat position of node n on level l of the implicit tree.
    function automatic int unsigned node_slot(input int unsigned lvl, input int unsigned node);
        return ((1 << lvl) - 1) + node;
    endfunction

    // Marks one leaf in the tree model and walks up to the root, producing
    // the status and root state that the block must report.
    function automatic void apply_page_mark(input logic mark_full,
                                            input logic [PAGE_FIELD_W-1:0] page,
                                            output status_t walk_status,
                                            output node_state_t root);
        int unsigned lvl;
        int unsigned node;
        int unsigned pos;
        node_state_t left;
        node_state_t right;
        bit          stop;
        lvl = PAGE_BITS;
        node = page & (LEAF_COUNT - 1);
        walk_status = STATUS_OK;
        stop = 1'b0;
        tree_model[node_slot(lvl, node)] = mark_full ? ST_FULL : ST_UNAVAIL;
        while (lvl > 0 && !stop)
        begin
            lvl = lvl - 1;
            node = node >> 1;
            pos = node_slot(lvl, node);
            case (tree_model[pos])
                ST_AVAIL: tree_model[pos] = ST_PARTIAL;
                ST_UNAVAIL:
                begin
                    walk_status = STATUS_UNAVAIL;
                    stop = 1'b1;
                end
                ST_FULL:
                begin
                    walk_status = STATUS_FULL;
                    stop = 1'b1;
                end
                default:
                begin
                    // A partial parent settles only once both children are done.
                    left = tree_model[node_slot(lvl + 1, node << 1)];
                    right = tree_model[node_slot(lvl + 1, (node << 1) + 1)];
                    if (left == ST_AVAIL || right == ST_AVAIL ||
                        left == ST_PARTIAL || right == ST_PARTIAL)
                        stop = 1'b1;
                    else if (left == ST_UNAVAIL && right == ST_UNAVAIL)
                        tree_model[pos] = ST_UNAVAIL;
                    else
                        tree_model[pos] = ST_FULL;
                end
            endcase
        end
        root = tree_model[0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Random gap after a command beat: mostly short, a few long.
    task automatic idle_sender();
        int unsigned pick;
        int unsigned gap;
        pick = $urandom_range(0, 99);
        if (no_gaps || pick < 45)
            gap = 0;
        else if (pick < 80)
            gap = $urandom_range(1, 3);
        else if (pick < 96)
            gap = $urandom_range(4, 12);
        else
            gap = $urandom_range(20, 60);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Sends one command beat and records the expected result.
    task automatic mark_page(input logic mark_full, input logic [PAGE_FIELD_W-1:0] page);
        mark_outcome_t outcome;
        start <= 1'b1;
        kind <= mark_full;
        page_index <= page;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        outcome.page = page;
        apply_page_mark(mark_full, page, outcome.status, outcome.root);
        owed_outcomes.push_back(outcome);
        items_sent++;
        idle_sender();
    endtask

    // Holds off new commands until every outstanding result has come back.
    task automatic drain_results();
        start <= 1'b0;
        while (owed_outcomes.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic shuffle_pages(ref logic [PAGE_FIELD_W-1:0] pages[$]);
        int unsigned j;
        logic [PAGE_FIELD_W-1:0] held;
        for (int i = pages.size() - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            held = pages[i];
            pages[i] = pages[j];
            pages[j] = held;
        end
    endtask

    // First and last pages, and pages on both sides of the root split.
    task automatic test_extreme_pages();
        no_gaps = 1'b1;
        mark_page(1'b0, 10'd0);
        mark_page(1'b1, 10'd1023);
        mark_page(1'b0, 10'd512);
        mark_page(1'b1, 10'd511);
        no_gaps = 1'b0;
    endtask

    // Siblings completing a parent as unavailable, full and mixed.
    task automatic test_sibling_merge();
        mark_page(1'b0, 10'd1);
        mark_page(1'b0, 10'd2);
        mark_page(1'b0, 10'd3);
        mark_page(1'b1, 10'd1022);
        mark_page(1'b1, 10'd4);
        mark_page(1'b0, 10'd5);
    endtask

    // Marked leaves written again, running into unavailable, full and partial parents.
    task automatic test_leaf_overwrite();
        mark_page(1'b1, 10'd0);
        mark_page(1'b0, 10'd1023);
        mark_page(1'b0, 10'd700);
        mark_page(1'b1, 10'd700);
    endtask

    // A block of eight pages settled in order, so the walk climbs several levels.
    task automatic test_deep_walk();
        for (int i = 128; i < 136; i++)
            mark_page(1'b0, i[PAGE_FIELD_W-1:0]);
    endtask

    // Aligned blocks of pages filled in random order, with stray pages mixed in.
    task automatic test_random_blocks();
        int unsigned size_log;
        int unsigned base;
        int unsigned target;
        run_mode_t   mode;
        logic [PAGE_FIELD_W-1:0] pages[$];
        logic        mark_full;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 99) < 15)
                mark_page(1'($urandom_range(0, 1)),
                          PAGE_FIELD_W'($urandom_range(0, LEAF_COUNT - 1)));
            else
            begin
                size_log = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7)
                                                       : $urandom_range(1, 4);
                base = $urandom_range(0, (LEAF_COUNT >> size_log) - 1) << size_log;
                mode = run_mode_t'($urandom_range(0, 2));
                no_gaps = ($urandom_range(0, 3) == 0);
                pages.delete();
                for (int i = 0; i < (1 << size_log); i++)
                    pages.push_back(PAGE_FIELD_W'(base + i));
                shuffle_pages(pages);
                foreach (pages[i])
                begin
                    if (mode == RUN_UNAVAIL)
                        mark_full = 1'b0;
                    else if (mode == RUN_FULL)
                        mark_full = 1'b1;
                    else
                        mark_full = 1'($urandom_range(0, 1));
                    mark_page(mark_full, pages[i]);
                end
                no_gaps = 1'b0;
            end
            // Let everything come back whenever the item count lands on a multiple of 400.
            if (owed_outcomes.size() != 0 && items_sent % 400 == 0)
                drain_results();
        end
    endtask

    // Every page still free gets marked, so the walk finally settles the root.
    task automatic test_fill_remaining();
        logic [PAGE_FIELD_W-1:0] pages[$];
        for (int i = 0; i < LEAF_COUNT; i++)
            if (tree_model[node_slot(PAGE_BITS, i)] == ST_AVAIL)
                pages.push_back(PAGE_FIELD_W'(i));
        shuffle_pages(pages);
        foreach (pages[i])
            mark_page(1'($urandom_range(0, 1)), pages[i]);
        // A few more after the root has settled.
        for (int i = 0; i < 8; i++)
            mark_page(1'($urandom_range(0, 1)),
                      PAGE_FIELD_W'($urandom_range(0, LEAF_COUNT - 1)));
    endtask

    // Each result beat is compared with the oldest expectation.
    always @(posedge clk)
    begin
        mark_outcome_t outcome;
        if (rst_n && done)
        begin
            if (owed_outcomes.size() == 0)
                report_mismatch($sformatf("result with none expected, status %0d root %0d",
                                          status, root_state));
            else
            begin
                outcome = owed_outcomes.pop_front();
                if (status !== outcome.status)
                    report_mismatch($sformatf("page %0d status %0d, expected %0d",
                                              outcome.page, status, outcome.status));
                if (root_state !== outcome.root)
                    report_mismatch($sformatf("page %0d root %0d, expected %0d",
                                              outcome.page, root_state, outcome.root));
            end
        end
    end

    // Watchdog on cycles without any command or result beat.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("page_state_tree_update_test: FAIL");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        kind = 1'b0;
        page_index = '0;
        mismatch_count = 0;
        items_sent = 0;
        quiet_cycles = 0;
        no_gaps = 1'b0;
        for (int i = 0; i < TREE_NODES; i++)
            tree_model[i] = ST_AVAIL;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_extreme_pages();
        test_sibling_merge();
        drain_results();
        test_leaf_overwrite();
        test_deep_walk();
        drain_results();
        test_random_blocks();
        test_fill_remaining();

        drain_results();
        repeat (SETTLE) @(posedge clk);
        if (mismatch_count == 0)
            $display("page_state_tree_update_test: PASS");
        else
            $display("page_state_tree_update_test: FAIL");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/pst_pkg.sv
rtl/pst_ram.sv
rtl/page_state_tree_update.sv
rtl/pst_checker.sv
test/page_state_tree_update_test.sv
